[rtl/core/nnds_pkg.sv]
`default_nettype none

package nnds_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int DIM_W   = 10;
    localparam int STEP_W  = 13;
    localparam int ORG_W   = 12;
    localparam int COORD_W = 13;
    localparam int PIX_W   = 8;
    localparam int ACC_W   = 13;
    localparam int T_W     = ACC_W + 1;
    localparam int REP_W   = 4;
    localparam int SUB_W   = 3;
    localparam int IDX_W   = 3;

    localparam logic [ACC_W-1:0]  UNIT        = ACC_W'(1000);
    localparam logic [STEP_W-1:0] MIN_STEP    = STEP_W'(125);
    localparam logic [PIX_W-1:0]  TRANSPARENT = PIX_W'(8'hFF);

    typedef enum logic [IDX_W-1:0] {
        CFG_STEP     = 3'd0,
        CFG_WIDTH    = 3'd1,
        CFG_HEIGHT   = 3'd2,
        CFG_ORIGIN_X = 3'd3,
        CFG_ORIGIN_Y = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [ORG_W-1:0]  origin_x;
        logic [ORG_W-1:0]  origin_y;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_VINIT,
        OP_VLOOP,
        OP_HINIT,
        OP_HLOOP,
        OP_EINIT,
        OP_EMIT,
        OP_UPDATE
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_COL_NZ,
        COND_T_NEG,
        COND_NO_EMIT,
        COND_EMIT_MORE
    } cond_t;

    typedef logic [3:0] pc_t;

    localparam pc_t PC_FETCH  = 4'd0;
    localparam pc_t PC_CHKCOL = 4'd1;
    localparam pc_t PC_VINIT  = 4'd2;
    localparam pc_t PC_VLOOP  = 4'd3;
    localparam pc_t PC_HINIT  = 4'd4;
    localparam pc_t PC_HLOOP  = 4'd5;
    localparam pc_t PC_ECHK   = 4'd6;
    localparam pc_t PC_EMIT   = 4'd7;
    localparam pc_t PC_UPDATE = 4'd8;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    typedef struct packed {
        logic no_input;
        logic col_nz;
        logic t_neg;
        logic no_emit;
        logic emit_more;
    } status_t;

    function automatic uword_t ucode_rom(pc_t pc);
        uword_t w;
        unique case (pc)
            PC_FETCH:  w = '{OP_FETCH,  COND_NO_INPUT,  PC_FETCH};
            PC_CHKCOL: w = '{OP_NOP,    COND_COL_NZ,    PC_HINIT};
            PC_VINIT:  w = '{OP_VINIT,  COND_NEVER,     PC_FETCH};
            PC_VLOOP:  w = '{OP_VLOOP,  COND_T_NEG,     PC_VLOOP};
            PC_HINIT:  w = '{OP_HINIT,  COND_NEVER,     PC_FETCH};
            PC_HLOOP:  w = '{OP_HLOOP,  COND_T_NEG,     PC_HLOOP};
            PC_ECHK:   w = '{OP_EINIT,  COND_NO_EMIT,   PC_UPDATE};
            PC_EMIT:   w = '{OP_EMIT,   COND_EMIT_MORE, PC_EMIT};
            PC_UPDATE: w = '{OP_UPDATE, COND_ALWAYS,    PC_FETCH};
            default:   w = '{OP_NOP,    COND_ALWAYS,    PC_FETCH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/core/nnds_if.sv]
`default_nettype none

interface nnds_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface nnds_result_if;
    logic        valid;
    logic        ready;
    logic [12:0] out_x;
    logic [12:0] out_y;
    logic [7:0]  color;
    logic        last;

    modport source (output valid, output out_x, output out_y, output color, output last,
                    input ready);
    modport sink   (input valid, input out_x, input out_y, input color, input last,
                    output ready);
endinterface

`default_nettype wire

[rtl/core/nnds_seq.sv]
`default_nettype none

module nnds_seq
    import nnds_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire status_t status,
    output op_t          op
);

    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t uword;
    logic   take;

    assign uword = ucode_rom(pc_reg);
    assign op    = uword.op;

    always_comb
    begin
        unique case (uword.cond)
            COND_NEVER:     take = 1'b0;
            COND_ALWAYS:    take = 1'b1;
            COND_NO_INPUT:  take = status.no_input;
            COND_COL_NZ:    take = status.col_nz;
            COND_T_NEG:     take = status.t_neg;
            COND_NO_EMIT:   take = status.no_emit;
            COND_EMIT_MORE: take = status.emit_more;
            default:        take = 1'b1;
        endcase
    end

    assign pc_next = take ? uword.target : pc_t'(pc_reg + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/nnds_dp.sv]
`default_nettype none

module nnds_dp
    import nnds_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire op_t      op,
    output status_t       status,
    nnds_pixel_if.sink    pixels,
    nnds_result_if.source results
);

    // architectural state
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [ACC_W-1:0]   hacc_reg, hacc_next;
    logic [ACC_W-1:0]   vacc_reg, vacc_next;
    logic [COORD_W-1:0] scol_reg, scol_next;
    logic [COORD_W-1:0] base_reg, base_next;
    logic [REP_W-1:0]   rrc_reg, rrc_next;
    logic [REP_W-1:0]   cols_reg, cols_next;
    logic               out_valid_reg, out_valid_next;

    // working registers
    logic [PIX_W-1:0]   pix_reg, pix_next;
    logic signed [T_W-1:0] t_reg, t_next;
    logic [REP_W-1:0]   n_reg, n_next;
    logic [SUB_W-1:0]   cc_reg, cc_next;
    logic [SUB_W-1:0]   rc_reg, rc_next;
    logic [COORD_W-1:0] ox_reg, ox_next;
    logic [COORD_W-1:0] oy_reg, oy_next;
    logic [PIX_W-1:0]   color_reg, color_next;
    logic               last_reg, last_next;

    logic [STEP_W-1:0]  step_eff;
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [COL_W:0]     col_inc;
    logic [ROW_W:0]     row_inc;
    logic               slot_free;
    logic               col_end;
    logic               row_end;
    logic               final_hit;
    logic signed [T_W-1:0] t_step;

    assign step_eff = (cfg.step < MIN_STEP) ? MIN_STEP : cfg.step;

    always_comb
    begin
        if (cfg.width == '0)
            w_eff = DIM_W'(1);
        else if (int'(cfg.width) > MAX_WIDTH)
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = cfg.width;
        if (cfg.height == '0)
            h_eff = DIM_W'(1);
        else if (int'(cfg.height) > MAX_HEIGHT)
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = cfg.height;
    end

    assign col_inc   = {1'b0, col_reg} + 1'b1;
    assign row_inc   = {1'b0, row_reg} + 1'b1;
    assign col_end   = int'(col_inc) >= int'(w_eff);
    assign row_end   = int'(row_inc) >= int'(h_eff);
    assign slot_free = !out_valid_reg || results.ready;
    assign final_hit = (REP_W'(cc_reg) + 1'b1 == cols_reg) && (REP_W'(rc_reg) + 1'b1 == rrc_reg);
    assign t_step    = t_reg + T_W'(step_eff);

    assign pixels.ready = (op == OP_FETCH);

    assign status.no_input  = !pixels.valid;
    assign status.col_nz    = (col_reg != '0);
    assign status.t_neg     = t_reg[T_W-1];
    assign status.no_emit   = (pix_reg == TRANSPARENT) || (rrc_reg == '0) || (cols_reg == '0);
    assign status.emit_more = !(slot_free && final_hit);

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        hacc_next      = hacc_reg;
        vacc_next      = vacc_reg;
        scol_next      = scol_reg;
        base_next      = base_reg;
        rrc_next       = rrc_reg;
        cols_next      = cols_reg;
        out_valid_next = out_valid_reg && !results.ready;
        pix_next       = pix_reg;
        t_next         = t_reg;
        n_next         = n_reg;
        cc_next        = cc_reg;
        rc_next        = rc_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        color_next     = color_reg;
        last_next      = last_reg;

        unique case (op)
            OP_NOP:
            begin
            end
            OP_FETCH:
            begin
                if (pixels.valid)
                    pix_next = pixels.pixel;
            end
            OP_VINIT:
            begin
                t_next = $signed({1'b0, vacc_reg}) - $signed({1'b0, UNIT});
                n_next = '0;
            end
            OP_VLOOP:
            begin
                if (t_reg[T_W-1])
                begin
                    t_next = t_step;
                    n_next = n_reg + 1'b1;
                end
                else
                begin
                    vacc_next = ACC_W'(t_reg);
                    rrc_next  = n_reg;
                end
            end
            OP_HINIT:
            begin
                t_next = $signed({1'b0, hacc_reg}) - $signed({1'b0, UNIT});
                n_next = '0;
            end
            OP_HLOOP:
            begin
                if (t_reg[T_W-1])
                begin
                    t_next = t_step;
                    n_next = n_reg + 1'b1;
                end
                else
                begin
                    hacc_next = ACC_W'(t_reg);
                    cols_next = n_reg;
                end
            end
            OP_EINIT:
            begin
                cc_next = '0;
                rc_next = '0;
            end
            OP_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    ox_next    = COORD_W'({1'b0, cfg.origin_x}) + scol_reg + COORD_W'(cc_reg);
                    oy_next    = COORD_W'({1'b0, cfg.origin_y}) + base_reg + COORD_W'(rc_reg);
                    color_next = pix_reg;
                    last_next  = final_hit;
                    if (REP_W'(cc_reg) + 1'b1 == cols_reg)
                    begin
                        cc_next = '0;
                        rc_next = rc_reg + 1'b1;
                    end
                    else
                    begin
                        cc_next = cc_reg + 1'b1;
                    end
                end
            end
            OP_UPDATE:
            begin
                scol_next = scol_reg + COORD_W'(cols_reg);
                col_next  = COL_W'(col_inc);
                if (col_end)
                begin
                    col_next  = '0;
                    scol_next = '0;
                    hacc_next = '0;
                    base_next = base_reg + COORD_W'(rrc_reg);
                    row_next  = ROW_W'(row_inc);
                    if (row_end)
                    begin
                        row_next  = '0;
                        base_next = '0;
                        vacc_next = '0;
                        rrc_next  = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            hacc_reg      <= '0;
            vacc_reg      <= '0;
            scol_reg      <= '0;
            base_reg      <= '0;
            rrc_reg       <= '0;
            cols_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            hacc_reg      <= hacc_next;
            vacc_reg      <= vacc_next;
            scol_reg      <= scol_next;
            base_reg      <= base_next;
            rrc_reg       <= rrc_next;
            cols_reg      <= cols_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg   <= pix_next;
        t_reg     <= t_next;
        n_reg     <= n_next;
        cc_reg    <= cc_next;
        rc_reg    <= rc_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        color_reg <= color_next;
        last_reg  <= last_next;
    end

    assign results.valid = out_valid_reg;
    assign results.out_x = ox_reg;
    assign results.out_y = oy_reg;
    assign results.color = color_reg;
    assign results.last  = last_reg;

endmodule

`default_nettype wire

[rtl/core/nearest_neighbor_dda_scaler_top.sv]
// Per accepted pixel: at the first pixel of a row the vertical accumulator loop runs n_v
// iterations, then the horizontal loop runs n_h iterations, then the results are emitted
// and the position is updated; n_h and n_v (0..8) are the accumulator iterations.
// A new pixel is accepted only after the last one's position update. The microcode loop
// steps one iteration or one result per cycle; output stalls hold the result loop.
// Reset: rst_n asynchronous, active low; clears image position and accumulators and loads
// register defaults (step 1000, 320 x 200, origin 0,0).
`default_nettype none

module nearest_neighbor_dda_scaler_top
    import nnds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    nnds_pixel_if.sink             pixels,
    nnds_result_if.source          results,
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [STEP_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    op_t     op;
    status_t status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEP:     cfg_next.step     = cfg_data;
                CFG_WIDTH:    cfg_next.width    = cfg_data[DIM_W-1:0];
                CFG_HEIGHT:   cfg_next.height   = cfg_data[DIM_W-1:0];
                CFG_ORIGIN_X: cfg_next.origin_x = cfg_data[ORG_W-1:0];
                CFG_ORIGIN_Y: cfg_next.origin_y = cfg_data[ORG_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step     <= STEP_W'(1000);
            cfg_reg.width    <= DIM_W'(320);
            cfg_reg.height   <= DIM_W'(200);
            cfg_reg.origin_x <= '0;
            cfg_reg.origin_y <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    nnds_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    nnds_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .op      (op),
        .status  (status),
        .pixels  (pixels),
        .results (results)
    );

endmodule

`default_nettype wire
